>>> rtl/tdk_pkg.sv
// Shared types, widths and constants for the target distance kinematics unit.
`timescale 1ns / 1ps
package tdk_pkg;

  // Default parameter values
  localparam int COORD_BITS_DEF       = 12;
  localparam int FRAC_BITS_DEF        = 8;
  localparam int TICKS_PER_SECOND_DEF = 1000;

  // Fixed field widths
  localparam int DIST_W     = 21;
  localparam int STAMP_W    = 32;
  localparam int SPEED_W    = 32;
  localparam int ACCEL_W    = 48;
  localparam int BTN_W      = 8;
  localparam int CFG_COORD_W = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 21;

  // Shared compare/subtract unit width: 32-bit divisor plus one shifted-in bit
  localparam int UNIT_W = STAMP_W + 1;

  // Saturation limits
  localparam logic [DIST_W-1:0] DIST_MAX    = {DIST_W{1'b1}};
  localparam logic [63:0]       SPEED_MAX   = 64'h0000_0000_FFFF_FFFF;
  localparam logic [63:0]       ACC_POS_MAX = 64'h0000_7FFF_FFFF_FFFF;
  localparam logic [63:0]       ACC_NEG_MAG = 64'h0000_8000_0000_0000;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIX_X_EN  = 3'd0,
    CFG_FIX_X     = 3'd1,
    CFG_FIX_Y_EN  = 3'd2,
    CFG_FIX_Y     = 3'd3,
    CFG_FIXED_LIM = 3'd4
  } cfg_idx_t;

  // Configuration register set
  typedef struct packed {
    logic                   fix_x_en;
    logic [CFG_COORD_W-1:0] fix_x;
    logic                   fix_y_en;
    logic [CFG_COORD_W-1:0] fix_y;
    logic [DIST_W-1:0]      fixed_limit;
  } cfg_t;

endpackage

>>> rtl/tdk_cfg_regs.sv
// Configuration register file of the target distance kinematics unit.
`timescale 1ns / 1ps
module tdk_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tdk_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tdk_pkg::CFG_DATA_W-1:0]   cfg_data,
  output tdk_pkg::cfg_t                    cfg
);
  import tdk_pkg::*;

  cfg_t cfg_r;

  // Always take writes
  assign cfg_ready = 1'b1;
  assign cfg      = cfg_r;

  // Decode index and update one register per transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_FIX_X_EN:  cfg_r.fix_x_en    <= cfg_data[0];
        CFG_FIX_X:     cfg_r.fix_x       <= cfg_data[CFG_COORD_W-1:0];
        CFG_FIX_Y_EN:  cfg_r.fix_y_en    <= cfg_data[0];
        CFG_FIX_Y:     cfg_r.fix_y       <= cfg_data[CFG_COORD_W-1:0];
        CFG_FIXED_LIM: cfg_r.fixed_limit <= cfg_data[DIST_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/tdk_cmpsub.sv
// Shared compare-and-subtract step used by the square root and the divider.
`timescale 1ns / 1ps
module tdk_cmpsub (
  input  logic [tdk_pkg::UNIT_W-1:0] op_a,
  input  logic [tdk_pkg::UNIT_W-1:0] op_b,
  output logic                       ge,
  output logic [tdk_pkg::UNIT_W-1:0] res
);
  import tdk_pkg::*;

  logic [UNIT_W:0] diff;

  // Subtract with borrow out; keep the minuend when the trial fails
  assign diff = {1'b0, op_a} - {1'b0, op_b};
  assign ge   = ~diff[UNIT_W];
  assign res  = ge ? diff[UNIT_W-1:0] : op_a;

endmodule

>>> rtl/target_distance_kinematics_unit.sv
// Top level: distance to target, speed, acceleration and distance limit per sample.
`timescale 1ns / 1ps
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+------------------------------
//  input   | in_pos_x/y, in_stamp, in_button, ...    | in_valid / in_stall
//  result  | out_dist_res ... out_button_out         | out_valid / out_stall
//  config  | cfg_index, cfg_data                     | cfg_valid / cfg_ready (always 1)
//
//  TPS_W is the bit width of TICKS_PER_SECOND (10 at the defaults).
//  A run's first sample or a zero interval skips both divisions.
//  Root (21 steps) and divisions (21 + TPS_W, 32 + TPS_W steps) share one subtract unit.
//  rst_n is synchronous, active low, and clears all kinematic state and targets.
//  A stalled result holds the sequencer at its last step; no new sample is taken meanwhile.
module target_distance_kinematics_unit #(
  parameter int COORD_BITS       = tdk_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS        = tdk_pkg::FRAC_BITS_DEF,
  parameter int TICKS_PER_SECOND = tdk_pkg::TICKS_PER_SECOND_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [COORD_BITS-1:0]               in_pos_x,
  input  logic [COORD_BITS-1:0]               in_pos_y,
  input  logic [tdk_pkg::STAMP_W-1:0]         in_stamp,
  input  logic [tdk_pkg::BTN_W-1:0]           in_button,
  input  logic                                in_run_start,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [tdk_pkg::DIST_W-1:0]          out_dist_res,
  output logic [tdk_pkg::SPEED_W-1:0]         out_speed,
  output logic                                out_speed_ok,
  output logic signed [tdk_pkg::ACCEL_W-1:0]  out_accel,
  output logic                                out_accel_ok,
  output logic                                out_zero_interval,
  output logic                                out_target_mismatch,
  output logic [tdk_pkg::DIST_W-1:0]          out_dist_limit,
  output logic [tdk_pkg::BTN_W-1:0]           out_button_out,
  // configuration channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tdk_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tdk_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import tdk_pkg::*;

  localparam int TPS_W   = $clog2(TICKS_PER_SECOND + 1);
  localparam int MB      = (COORD_BITS > TPS_W) ? COORD_BITS : TPS_W;
  localparam int PW      = SPEED_W + MB;
  localparam int SUM_W   = 2 * COORD_BITS + 1;
  localparam int RAD_W   = 2 * DIST_W;
  localparam int SQ_REM_W = DIST_W + 2;
  localparam int OVF_SH  = RAD_W - 2 * FRAC_BITS;
  localparam int NW_S    = DIST_W + TPS_W;
  localparam int NW_A    = SPEED_W + TPS_W;
  localparam int CNT_W   = $clog2(NW_A + 1);
  localparam logic [MB-1:0]     TPS_K    = MB'(TICKS_PER_SECOND);
  localparam logic [DIST_W:0]   ONE_PIX  = (DIST_W + 1)'(1) << FRAC_BITS;

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_TGT    = 14'b00000000000010,
    S_MULX   = 14'b00000000000100,
    S_MULY   = 14'b00000000001000,
    S_SUM    = 14'b00000000010000,
    S_SQRT   = 14'b00000000100000,
    S_DIST   = 14'b00000001000000,
    S_SPINIT = 14'b00000010000000,
    S_SPDIV  = 14'b00000100000000,
    S_SPD    = 14'b00001000000000,
    S_ACINIT = 14'b00010000000000,
    S_ACDIV  = 14'b00100000000000,
    S_ACC    = 14'b01000000000000,
    S_DONE   = 14'b10000000000000
  } state_t;

  cfg_t cfg;

  // Control and kinematic state
  state_t                  state_r, state_nxt;
  logic                    out_valid_r;
  logic [COORD_BITS-1:0]   target_x_r, target_y_r;
  logic                    target_x_known_r, target_y_known_r;
  logic [STAMP_W-1:0]      last_stamp_r;
  logic [DIST_W-1:0]       last_dist_r;
  logic [SPEED_W-1:0]      last_speed_r;
  logic                    last_speed_ok_r;
  logic [1:0]              samples_seen_r;
  logic [DIST_W-1:0]       running_max_r;

  // Per-sample working registers
  logic [COORD_BITS-1:0]   x_r, y_r;
  logic [STAMP_W-1:0]      stamp_r;
  logic [BTN_W-1:0]        button_r;
  logic                    first_r, mismatch_r, zero_r, sp_ok_r, ac_ok_r, neg_r, ovf_r;
  logic [PW-1:0]           prod_r;
  logic [SUM_W-1:0]        acc_r;
  logic [RAD_W-1:0]        rad_r;
  logic [DIST_W-1:0]       root_r, dist_r;
  logic [STAMP_W-1:0]      rem_r, dt_r;
  logic [NW_A-1:0]         num_r, q_r;
  logic [CNT_W-1:0]        cnt_r;
  logic [SPEED_W-1:0]      speed_r;
  logic [ACCEL_W-1:0]      accel_r;

  // Output payload registers
  logic [DIST_W-1:0]       o_dist_r, o_limit_r;
  logic [SPEED_W-1:0]      o_speed_r;
  logic [ACCEL_W-1:0]      o_accel_r;
  logic                    o_sp_ok_r, o_ac_ok_r, o_zero_r, o_mis_r;
  logic [BTN_W-1:0]        o_button_r;

  // Combinational helpers
  logic [COORD_BITS-1:0]   dx, dy, fx, fy;
  logic [DIST_W-1:0]       dd, rmax_base;
  logic [STAMP_W-1:0]      dt;
  logic [SPEED_W-1:0]      spd_sat, mag;
  logic                    spd_neg;
  logic [SUM_W-1:0]        sum;
  logic [63:0]             sum64, q64;
  logic [SPEED_W-1:0]      mul_a;
  logic [MB-1:0]           mul_b;
  logic [PW-1:0]           mul_p;
  logic [UNIT_W-1:0]       u_a, u_b, u_res;
  logic                    u_ge;
  logic [ACCEL_W-1:0]      acc_mag;
  logic [DIST_W:0]         lim_sum;
  logic [DIST_W-1:0]       limit;
  logic                    out_load, last_step;

  tdk_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tdk_cmpsub u_unit (
    .op_a (u_a),
    .op_b (u_b),
    .ge   (u_ge),
    .res  (u_res)
  );

  // Handshake outputs
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || !out_stall);
  assign last_step = (cnt_r == CNT_W'(1));

  // Axis differences and configured targets
  assign fx = COORD_BITS'(cfg.fix_x);
  assign fy = COORD_BITS'(cfg.fix_y);
  assign dx = (x_r >= target_x_r) ? x_r - target_x_r : target_x_r - x_r;
  assign dy = (y_r >= target_y_r) ? y_r - target_y_r : target_y_r - y_r;

  // Sum of squares, widened for the overflow test and radicand
  assign sum   = acc_r + prod_r[SUM_W-1:0];
  assign sum64 = 64'(sum);

  // Interval, distance change, speed saturation and speed change
  assign dt        = (stamp_r >= last_stamp_r) ? stamp_r - last_stamp_r
                                               : last_stamp_r - stamp_r;
  assign dd        = (dist_r >= last_dist_r) ? dist_r - last_dist_r : last_dist_r - dist_r;
  assign rmax_base = first_r ? '0 : running_max_r;
  assign q64       = 64'(q_r);
  assign spd_sat   = (q64 > SPEED_MAX) ? SPEED_MAX[SPEED_W-1:0] : q_r[SPEED_W-1:0];
  assign spd_neg   = spd_sat < last_speed_r;
  assign mag       = spd_neg ? last_speed_r - spd_sat : spd_sat - last_speed_r;

  // Acceleration magnitude with saturation on each side
  always_comb begin
    if (neg_r) begin
      acc_mag = (q64 > ACC_NEG_MAG) ? ACC_NEG_MAG[ACCEL_W-1:0] : q64[ACCEL_W-1:0];
    end else begin
      acc_mag = (q64 > ACC_POS_MAX) ? ACC_POS_MAX[ACCEL_W-1:0] : q64[ACCEL_W-1:0];
    end
  end

  // Distance limit: fixed value or running maximum plus one pixel
  assign lim_sum = {1'b0, running_max_r} + ONE_PIX;
  assign limit   = (cfg.fixed_limit != '0) ? cfg.fixed_limit :
                   (lim_sum[DIST_W] ? DIST_MAX : lim_sum[DIST_W-1:0]);

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_MULX: begin
        mul_a = SPEED_W'(dx);
        mul_b = MB'(dx);
      end
      S_MULY: begin
        mul_a = SPEED_W'(dy);
        mul_b = MB'(dy);
      end
      S_DIST: begin
        mul_a = SPEED_W'(dd);
        mul_b = TPS_K;
      end
      S_SPD: begin
        mul_a = mag;
        mul_b = TPS_K;
      end
      default: ;
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // Shared compare/subtract operand select: root trial or divisor trial
  always_comb begin
    if (state_r == S_SQRT) begin
      u_a = UNIT_W'({rem_r[SQ_REM_W-1:0], rad_r[RAD_W-1 -: 2]});
      u_b = UNIT_W'({root_r, 2'b01});
    end else begin
      u_a = {rem_r, num_r[NW_A-1]};
      u_b = UNIT_W'(dt_r);
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_TGT;
      S_TGT:    state_nxt = S_MULX;
      S_MULX:   state_nxt = S_MULY;
      S_MULY:   state_nxt = S_SUM;
      S_SUM:    state_nxt = S_SQRT;
      S_SQRT:   if (last_step) state_nxt = S_DIST;
      S_DIST: begin
        if (first_r || dt == '0) state_nxt = S_DONE;
        else                     state_nxt = S_SPINIT;
      end
      S_SPINIT: state_nxt = S_SPDIV;
      S_SPDIV:  if (last_step) state_nxt = S_SPD;
      S_SPD: begin
        if (samples_seen_r >= 2'd2 && last_speed_ok_r) state_nxt = S_ACINIT;
        else                                            state_nxt = S_DONE;
      end
      S_ACINIT: state_nxt = S_ACDIV;
      S_ACDIV:  if (last_step) state_nxt = S_ACC;
      S_ACC:    state_nxt = S_DONE;
      S_DONE:   if (out_load) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Control and kinematic state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_IDLE;
      out_valid_r      <= 1'b0;
      target_x_r       <= '0;
      target_y_r       <= '0;
      target_x_known_r <= 1'b0;
      target_y_known_r <= 1'b0;
      last_stamp_r     <= '0;
      last_dist_r      <= '0;
      last_speed_r     <= '0;
      last_speed_ok_r  <= 1'b0;
      samples_seen_r   <= '0;
      running_max_r    <= '0;
    end else begin
      state_r <= state_nxt;

      // Hold result until taken
      if (out_load)       out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;

      // Latch targets on the first sample of a run
      if (state_r == S_TGT && first_r) begin
        if (cfg.fix_x_en) begin
          target_x_r       <= fx;
          target_x_known_r <= 1'b1;
        end else if (!target_x_known_r) begin
          target_x_r       <= x_r;
          target_x_known_r <= 1'b1;
        end
        if (cfg.fix_y_en) begin
          target_y_r       <= fy;
          target_y_known_r <= 1'b1;
        end else if (!target_y_known_r) begin
          target_y_r       <= y_r;
          target_y_known_r <= 1'b1;
        end
      end

      // Track running maximum
      if (state_r == S_DIST) begin
        running_max_r <= (dist_r > rmax_base) ? dist_r : rmax_base;
      end

      // Commit history when the result leaves
      if (out_load) begin
        last_stamp_r    <= stamp_r;
        last_dist_r     <= dist_r;
        last_speed_r    <= speed_r;
        last_speed_ok_r <= sp_ok_r;
        if (first_r)                    samples_seen_r <= 2'd1;
        else if (samples_seen_r != 2'd2) samples_seen_r <= samples_seen_r + 2'd1;
      end
    end
  end

  // Datapath working registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          x_r        <= in_pos_x;
          y_r        <= in_pos_y;
          stamp_r    <= in_stamp;
          button_r   <= in_button;
          first_r    <= in_run_start || (samples_seen_r == 2'd0);
          mismatch_r <= 1'b0;
          zero_r     <= 1'b0;
          sp_ok_r    <= 1'b0;
          ac_ok_r    <= 1'b0;
          speed_r    <= '0;
          accel_r    <= '0;
        end
      end
      S_TGT: begin
        if (first_r) begin
          mismatch_r <= (!cfg.fix_x_en && target_x_known_r && target_x_r != x_r) ||
                        (!cfg.fix_y_en && target_y_known_r && target_y_r != y_r);
        end
      end
      S_MULX: prod_r <= mul_p;
      S_MULY: begin
        acc_r  <= prod_r[SUM_W-1:0];
        prod_r <= mul_p;
      end
      S_SUM: begin
        ovf_r  <= (sum64 >> OVF_SH) != 64'd0;
        rad_r  <= RAD_W'(sum64 << (2 * FRAC_BITS));
        root_r <= '0;
        rem_r  <= '0;
        cnt_r  <= CNT_W'(DIST_W);
      end
      S_SQRT: begin
        // One root digit per cycle
        rem_r  <= u_res[STAMP_W-1:0];
        root_r <= {root_r[DIST_W-2:0], u_ge};
        rad_r  <= rad_r << 2;
        cnt_r  <= cnt_r - CNT_W'(1);
        if (last_step) dist_r <= ovf_r ? DIST_MAX : {root_r[DIST_W-2:0], u_ge};
      end
      S_DIST: begin
        dt_r   <= dt;
        prod_r <= mul_p;
        if (!first_r && dt == '0) zero_r <= 1'b1;
      end
      S_SPINIT: begin
        num_r <= NW_A'(prod_r[NW_S-1:0]) << (NW_A - NW_S);
        q_r   <= '0;
        rem_r <= '0;
        cnt_r <= CNT_W'(NW_S);
      end
      S_SPDIV, S_ACDIV: begin
        // One quotient bit per cycle
        rem_r <= u_res[STAMP_W-1:0];
        q_r   <= {q_r[NW_A-2:0], u_ge};
        num_r <= num_r << 1;
        cnt_r <= cnt_r - CNT_W'(1);
      end
      S_SPD: begin
        speed_r <= spd_sat;
        sp_ok_r <= 1'b1;
        neg_r   <= spd_neg;
        prod_r  <= mul_p;
      end
      S_ACINIT: begin
        num_r <= prod_r[NW_A-1:0];
        q_r   <= '0;
        rem_r <= '0;
        cnt_r <= CNT_W'(NW_A);
      end
      S_ACC: begin
        accel_r <= neg_r ? ACCEL_W'(0) - acc_mag : acc_mag;
        ac_ok_r <= 1'b1;
      end
      default: ;
    endcase
  end

  // Output payload registers
  always_ff @(posedge clk) begin
    if (out_load) begin
      o_dist_r   <= dist_r;
      o_speed_r  <= speed_r;
      o_sp_ok_r  <= sp_ok_r;
      o_accel_r  <= accel_r;
      o_ac_ok_r  <= ac_ok_r;
      o_zero_r   <= zero_r;
      o_mis_r    <= mismatch_r;
      o_limit_r  <= limit;
      o_button_r <= button_r;
    end
  end

  assign out_dist_res        = o_dist_r;
  assign out_speed           = o_speed_r;
  assign out_speed_ok        = o_sp_ok_r;
  assign out_accel           = o_accel_r;
  assign out_accel_ok        = o_ac_ok_r;
  assign out_zero_interval   = o_zero_r;
  assign out_target_mismatch = o_mis_r;
  assign out_dist_limit      = o_limit_r;
  assign out_button_out      = o_button_r;

endmodule
